>>> hdl/window_mean_deviation_order_trigger_assert.svh
// assertion macros shared by the order trigger modules
// expects clk and arst_n in the scope where a macro is used
`ifndef WINDOW_MEAN_DEVIATION_ORDER_TRIGGER_ASSERT_SVH
`define WINDOW_MEAN_DEVIATION_ORDER_TRIGGER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WMDOT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define WMDOT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/wmdot_pkg.sv
// shared types and constants of the moving-average deviation order trigger
// no dependencies
`default_nettype none

package wmdot_pkg;

	// window geometry
	localparam int WINDOW = 16;
	localparam int PTR_W  = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int PRICE_W = 32;
	localparam int SUM_W  = PRICE_W + PTR_W;
	localparam int DELTA_W = SUM_W + 1;
	localparam int THR    = 2 * WINDOW;

	// register reset value
	localparam int LIMIT_W = 15;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(20);

	// event kinds, codes above REJECTED act as other
	localparam logic [2:0] ACT_TRADE    = 3'd0;
	localparam logic [2:0] ACT_ACK      = 3'd1;
	localparam logic [2:0] ACT_FILL     = 3'd2;
	localparam logic [2:0] ACT_REJECTED = 3'd3;

	// order side codes
	localparam logic [1:0] SIDE_NONE = 2'd0;
	localparam logic [1:0] SIDE_BUY  = 2'd1;
	localparam logic [1:0] SIDE_SELL = 2'd2;

	// one market event
	typedef struct packed {
		logic [2:0]         action;
		logic [31:0]        event_order_id;
		logic [15:0]        event_qty;
		logic [PRICE_W-1:0] trade_price;
		logic               ask_present;
		logic [PRICE_W-1:0] ask_price;
		logic               bid_present;
		logic [PRICE_W-1:0] bid_price;
		logic signed [15:0] current_position;
		logic [31:0]        next_id;
	} event_t;

endpackage

`default_nettype wire

>>> hdl/wmdot_ring_mem.sv
// price ring storage: one write port, one read port with registered data
// depends on wmdot_pkg
`default_nettype none

module wmdot_ring_mem
	import wmdot_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               rd_en,
	input  wire logic [PTR_W-1:0]   rd_addr,
	output logic      [PRICE_W-1:0] rd_data,
	input  wire logic               wr_en,
	input  wire logic [PTR_W-1:0]   wr_addr,
	input  wire logic [PRICE_W-1:0] wr_data
);

	logic [PRICE_W-1:0] mem [WINDOW];
	logic [PRICE_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data registered on rd_en
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> hdl/wmdot_window.sv
// input stage and window sum: ring pointer, sample count, ring memory and running sum
// depends on wmdot_pkg and wmdot_ring_mem
`default_nettype none

module wmdot_window
	import wmdot_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire event_t           ev,
	output logic                  s2_valid,
	input  wire logic             s2_adv,
	output event_t                ev_s2,
	output logic      [SUM_W-1:0] sum_s2,
	output logic                  full_s2
);

	logic [PTR_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   sum_q;
	logic               v1_q;
	logic               v2_q;
	event_t             ev_s1;
	logic               full_s1;
	logic               fresh_s1;
	logic [PTR_W-1:0]   addr_s1;
	logic [PRICE_W-1:0] old_price;
	logic [PRICE_W-1:0] old_eff;
	logic [SUM_W-1:0]   sum_next;
	logic               accept;
	logic               adv1;
	logic               trade_in;
	logic               trade_s1;

	// handshake between the stages
	assign adv1     = v1_q && (!v2_q || s2_adv);
	assign in_stall = v1_q && !adv1;
	assign accept   = in_valid && !in_stall;
	assign trade_in = (ev.action == ACT_TRADE);
	assign trade_s1 = (ev_s1.action == ACT_TRADE);

	// ring pointer and sample count (saturating at WINDOW) advance on each accepted trade
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
		end else if (accept && trade_in) begin
			ptr_q <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
			if (cnt_q < CNT_W'(WINDOW)) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (accept) begin
			v1_q <= 1'b1;
		end else if (adv1) begin
			v1_q <= 1'b0;
		end
	end

	// stage 1 payload, the ring slot is read in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1    <= ev;
			addr_s1  <= ptr_q;
			full_s1  <= (cnt_q >= CNT_W'(WINDOW - 1));
			fresh_s1 <= (cnt_q < CNT_W'(WINDOW));
		end
	end

	wmdot_ring_mem u_ring (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (ptr_q),
		.rd_data (old_price),
		.wr_en   (adv1 && trade_s1),
		.wr_addr (addr_s1),
		.wr_data (ev_s1.trade_price)
	);

	// a slot not yet written since reset counts as zero
	assign old_eff  = fresh_s1 ? '0 : old_price;
	assign sum_next = sum_q - SUM_W'(old_eff) + SUM_W'(ev_s1.trade_price);

	// running window sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (adv1 && trade_s1) begin
			sum_q <= sum_next;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv1) begin
			v2_q <= 1'b1;
		end else if (s2_adv) begin
			v2_q <= 1'b0;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv1) begin
			ev_s2   <= ev_s1;
			sum_s2  <= sum_next;
			full_s2 <= full_s1;
		end
	end

	assign s2_valid = v2_q;

endmodule

`default_nettype wire

>>> hdl/wmdot_decide.sv
// deviation test, pending order tracking, position limit and output register
// depends on wmdot_pkg and the assertion macro header
`default_nettype none

`include "window_mean_deviation_order_trigger_assert.svh"

module wmdot_decide
	import wmdot_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write_en,
	input  wire logic [LIMIT_W-1:0] cfg_write_data,
	input  wire logic               s2_valid,
	output logic                    s2_adv,
	input  wire event_t             ev_s2,
	input  wire logic [SUM_W-1:0]   sum_s2,
	input  wire logic               full_s2,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [1:0]         order_side,
	output logic      [PRICE_W-1:0] order_price,
	output logic      [31:0]        order_id_out
);

	logic [LIMIT_W-1:0]        limit_q;
	logic [31:0]               pending_q;
	logic                      out_valid_q;
	logic [1:0]                side_q;
	logic [PRICE_W-1:0]        price_q;
	logic [31:0]               id_q;
	logic                      clear;
	logic [31:0]               pend_mid;
	logic signed [DELTA_W-1:0] delta;
	logic signed [16:0]        pos;
	logic signed [16:0]        lim;
	logic                      buy;
	logic                      sell;
	logic                      trade;
	logic [1:0]                side_d;

	// output register frees when empty or taken
	assign s2_adv = s2_valid && (!out_valid_q || !out_stall);

	// position limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_write_en) begin
			limit_q <= cfg_write_data;
		end
	end

	// matching ack with zero quantity, fill or rejection clears the pending order
	assign clear = (pending_q != '0) && (ev_s2.event_order_id == pending_q) &&
		((ev_s2.action == ACT_FILL) || (ev_s2.action == ACT_REJECTED) ||
		((ev_s2.action == ACT_ACK) && (ev_s2.event_qty == '0)));
	assign pend_mid = clear ? '0 : pending_q;

	// delta = price * window - sum
	assign delta = $signed({1'b0, SUM_W'(ev_s2.trade_price) * SUM_W'(WINDOW)}) -
		$signed({1'b0, sum_s2});

	// position against the limit
	assign pos   = {ev_s2.current_position[15], ev_s2.current_position};
	assign lim   = $signed({2'b00, limit_q});
	assign trade = (ev_s2.action == ACT_TRADE) && full_s2 && (pend_mid == '0);

	assign buy  = trade && (delta > $signed(DELTA_W'(THR))) && ev_s2.ask_present &&
		(pos < lim);
	assign sell = trade && (delta < -$signed(DELTA_W'(THR))) && ev_s2.bid_present &&
		(pos > -lim);

	// side selection
	always_comb begin
		priority if (buy) begin
			side_d = SIDE_BUY;
		end else if (sell) begin
			side_d = SIDE_SELL;
		end else begin
			side_d = SIDE_NONE;
		end
	end

	// pending order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (s2_adv) begin
			pending_q <= (side_d != SIDE_NONE) ? ev_s2.next_id : pend_mid;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			side_q <= side_d;
			unique case (side_d)
				SIDE_BUY: begin
					price_q <= ev_s2.ask_price;
					id_q    <= ev_s2.next_id;
				end
				SIDE_SELL: begin
					price_q <= ev_s2.bid_price;
					id_q    <= ev_s2.next_id;
				end
				default: begin
					price_q <= '0;
					id_q    <= '0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign order_side   = side_q;
	assign order_price  = price_q;
	assign order_id_out = id_q;

	// an order only comes from a trade over a full window
	`WMDOT_ASSERT_SAME(a_order_from_trade, s2_adv && (side_d != SIDE_NONE), (ev_s2.action == ACT_TRADE) && full_s2, "order issued without full window trade")
	// a transaction with no order carries zero price and id
	`WMDOT_ASSERT_SAME(a_none_zero, out_valid_q && (side_q == SIDE_NONE), (price_q == '0) && (id_q == '0), "no-order transaction carries payload")
	// an issued order becomes the pending one
	`WMDOT_ASSERT_NEXT(a_pending_set, s2_adv && (side_d != SIDE_NONE), pending_q == $past(ev_s2.next_id), "issued id not pending")
	// no order while another one is still pending
	`WMDOT_ASSERT_SAME(a_no_double, s2_adv && (side_d != SIDE_NONE), !((pending_q != '0) && !clear), "order issued while one is pending")

endmodule

`default_nettype wire

>>> hdl/window_mean_deviation_order_trigger.sv
// Moving-average deviation order trigger. Each accepted market event yields exactly one
// result transaction, which passes through stage 1, stage 2 and the output register, and
// a new event can be accepted every cycle while in_stall is low. The ring slot about to be
// replaced is read from the price ring memory in the cycle the event is accepted, the
// window sum is updated as the event leaves stage 1, and the deviation test, pending order
// check and position limit are applied as it moves from stage 2 into the output register.
// Trades push their price into a window of the last 16 prices; once the window is full and
// no order is pending, a price above the mean by more than two ticks issues a buy at the
// ask and one below issues a sell at the bid. Zero-quantity acks, fills and rejections for
// the pending id clear it. The position_limit register (reset 20) is written with
// cfg_write_en; the user must write it only while idle, the block does not enforce this.
// top level, depends on wmdot_pkg, wmdot_window and wmdot_decide
`default_nettype none

module window_mean_deviation_order_trigger
	import wmdot_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write_en,
	input  wire logic [LIMIT_W-1:0] cfg_write_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         action,
	input  wire logic [31:0]        event_order_id,
	input  wire logic [15:0]        event_qty,
	input  wire logic [31:0]        trade_price,
	input  wire logic               ask_present,
	input  wire logic [31:0]        ask_price,
	input  wire logic               bid_present,
	input  wire logic [31:0]        bid_price,
	input  wire logic signed [15:0] current_position,
	input  wire logic [31:0]        next_id,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [1:0]         order_side,
	output logic      [31:0]        order_price,
	output logic      [31:0]        order_id_out
);

	event_t           ev;
	event_t           ev_s2;
	logic             s2_valid;
	logic             s2_adv;
	logic [SUM_W-1:0] sum_s2;
	logic             full_s2;

	// pack the input transaction
	always_comb begin
		ev.action           = action;
		ev.event_order_id   = event_order_id;
		ev.event_qty        = event_qty;
		ev.trade_price      = trade_price;
		ev.ask_present      = ask_present;
		ev.ask_price        = ask_price;
		ev.bid_present      = bid_present;
		ev.bid_price        = bid_price;
		ev.current_position = current_position;
		ev.next_id          = next_id;
	end

	wmdot_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ev       (ev),
		.s2_valid (s2_valid),
		.s2_adv   (s2_adv),
		.ev_s2    (ev_s2),
		.sum_s2   (sum_s2),
		.full_s2  (full_s2)
	);

	wmdot_decide u_decide (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.s2_valid       (s2_valid),
		.s2_adv         (s2_adv),
		.ev_s2          (ev_s2),
		.sum_s2         (sum_s2),
		.full_s2        (full_s2),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.order_side     (order_side),
		.order_price    (order_price),
		.order_id_out   (order_id_out)
	);

endmodule

`default_nettype wire
